/* hw/rtl/pidl_pkg.sv */
package pidl_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int POS_W    = 7;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int WORD_W   = 32;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic [2:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_READ   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    // broadcast from control to every cell
    typedef struct packed {
        logic             push;
        logic             insert;
        logic             delete_en;
        logic [CMP_W-1:0] pos;
        logic [CMP_W-1:0] count;
    } t_cell_cmd;

    // result of the command decode
    typedef struct packed {
        t_status          status;
        logic             read_ok;
        logic [CNT_W-1:0] cur_count;
        logic [CNT_W-1:0] new_count;
    } t_ctrl_res;

endpackage

/* hw/rtl/pidl_in_if.sv */
interface pidl_in_if;
    logic                       valid;
    logic                       ready;
    logic [2:0]                 command;
    logic [pidl_pkg::POS_W-1:0] position;
    pidl_pkg::t_word            value;

    modport source (output valid, output command, output position, output value,
                    input ready);
    modport sink   (input valid, input command, input position, input value,
                    output ready);
endinterface

/* hw/rtl/pidl_out_if.sv */
interface pidl_out_if;
    logic            valid;
    logic            ready;
    logic [1:0]      status;
    logic [6:0]      count;
    pidl_pkg::t_word read_value;

    modport source (output valid, output status, output count, output read_value,
                    input ready);
    modport sink   (input valid, input status, input count, input read_value,
                    output ready);
endinterface

/* hw/rtl/pidl_cell.sv */
module pidl_cell (
    input  logic                       i_clk,
    input  logic [pidl_pkg::CMP_W-1:0] i_index,
    input  pidl_pkg::t_cell_cmd        i_cmd,
    input  pidl_pkg::t_word            i_value,
    input  pidl_pkg::t_word            i_left,
    input  pidl_pkg::t_word            i_right,
    output pidl_pkg::t_word            o_word
);
    import pidl_pkg::*;

    t_word r_word;
    t_word n_word;

    always_comb begin
        n_word = r_word;
        if (i_cmd.push) begin
            if (i_index == i_cmd.count) begin
                n_word = i_value;
            end
        end else if (i_cmd.insert) begin
            if (i_index == i_cmd.pos) begin
                n_word = i_value;
            end else if (i_index > i_cmd.pos) begin
                n_word = i_left;
            end
        end else if (i_cmd.delete_en) begin
            if (i_index >= i_cmd.pos) begin
                n_word = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

/* hw/rtl/pidl_ctrl.sv */
module pidl_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  logic [2:0]                 i_command,
    input  logic [pidl_pkg::POS_W-1:0] i_position,
    output pidl_pkg::t_cell_cmd        o_cmd,
    output pidl_pkg::t_ctrl_res        o_res
);
    import pidl_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic             full;
    logic             empty;
    t_status          status;
    logic             push_ok;
    logic             ins_ok;
    logic             del_ok;
    logic             read_ok;

    assign pos_ext = CMP_W'(i_position);
    assign cnt_ext = CMP_W'(r_count);
    assign full    = (cnt_ext >= CMP_W'(CAPACITY));
    assign empty   = (r_count == '0);

    always_comb begin
        status  = ST_OK;
        n_count = r_count;
        push_ok = 1'b0;
        ins_ok  = 1'b0;
        del_ok  = 1'b0;
        read_ok = 1'b0;
        case (t_cmd'(i_command))
            CMD_PUSH: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    push_ok = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_POP: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            CMD_INSERT: begin
                if (pos_ext > cnt_ext) begin
                    status = ST_BADPOS;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    ins_ok  = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_DELETE: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else if (pos_ext >= cnt_ext) begin
                    status = ST_BADPOS;
                end else begin
                    del_ok  = 1'b1;
                    n_count = r_count - CNT_W'(1);
                end
            end
            CMD_READ: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else if (pos_ext >= cnt_ext) begin
                    status = ST_BADPOS;
                end else begin
                    read_ok = 1'b1;
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_fire) begin
            r_count <= n_count;
        end
    end

    assign o_cmd.push      = i_fire & push_ok;
    assign o_cmd.insert    = i_fire & ins_ok;
    assign o_cmd.delete_en = i_fire & del_ok;
    assign o_cmd.pos       = pos_ext;
    assign o_cmd.count     = cnt_ext;

    assign o_res.status    = status;
    assign o_res.read_ok   = read_ok;
    assign o_res.cur_count = r_count;
    assign o_res.new_count = n_count;

endmodule

/* hw/rtl/positional_insert_delete_list.sv */
// Ordered list of up to CAPACITY signed 32-bit words (push, pop, insert at
// position, delete at position, read at position). Every command gives exactly
// one result: status, entry count after the command, and the read word (zero
// unless a read succeeded). A rejected command leaves the list untouched.
// The entries sit in a row of cells, one word per cell, and on insert or delete
// the cells from the position onward load the new word or their left or right
// neighbor in the same cycle, so the shift costs no extra time. A new command
// is taken whenever the output register is empty or its result transfers in
// the same cycle, giving a sustained rate of one command per cycle; the result
// is valid in the cycle after the input transfer. No clearing pass after
// reset: only entries below the count are ever read.
module positional_insert_delete_list (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pidl_in_if.sink           i_in,
    pidl_out_if.source        o_out
);
    import pidl_pkg::*;

    t_cell_cmd        cell_cmd;
    t_ctrl_res        res;
    t_word            cell_word [CAPACITY];
    t_word            rd_word;
    logic             in_fire;

    // output register
    logic             r_out_valid;
    t_status          r_status;
    logic [CNT_W-1:0] r_count;
    t_word            r_read;

    // accept while the result slot is free or draining this cycle
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;

    pidl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (in_fire),
        .i_command  (i_in.command),
        .i_position (i_in.position),
        .o_cmd      (cell_cmd),
        .o_res      (res)
    );

    // row of cells; the ends see zero from the missing neighbor
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        t_word left_w;
        t_word right_w;
        if (k == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = cell_word[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_mid_r
            assign right_w = cell_word[k+1];
        end
        pidl_cell u_cell (
            .i_clk   (i_clk),
            .i_index (CMP_W'(k)),
            .i_cmd   (cell_cmd),
            .i_value (i_in.value),
            .i_left  (left_w),
            .i_right (right_w),
            .o_word  (cell_word[k])
        );
    end

    // read tap; position is below count here, so it fits the index
    assign rd_word = cell_word[cell_cmd.pos[IDX_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_status <= res.status;
            r_count  <= res.new_count;
            r_read   <= res.read_ok ? rd_word : '0;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_status;
    assign o_out.count      = 7'(r_count);
    assign o_out.read_value = r_read;

`ifndef SYNTHESIS
    // count stays within capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.cur_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // a rejected command leaves the count where it was
    a_reject_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && res.status != ST_OK) |=> (res.cur_count == $past(res.cur_count)))
        else $error("rejected command changed the count");

    // only a good read carries a word
    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !res.read_ok) |=> (r_read == '0))
        else $error("read value not zero on non-read result");

    // a held result stays put while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_count)))
        else $error("stalled result changed");
`endif

endmodule

/* tb/sv/positional_insert_delete_list_test.sv */
module positional_insert_delete_list_test;
    import pidl_pkg::*;

    // One expected result per command: status, count after the command, read word
    typedef struct {
        t_status    status;
        logic [6:0] count;
        t_word      read_value;
    } t_list_result;

    logic i_clk;
    logic i_rst_n;

    pidl_in_if  in_bus ();
    pidl_out_if out_bus ();

    positional_insert_delete_list uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // Shadow copy of the list, updated at every accepted command transfer
    t_word        shadow_words [CAPACITY];
    int           shadow_len;
    t_list_result pending_results [$];

    // Bookkeeping for the checker and the closing summary
    int mismatch_count;
    int results_checked;
    int commands_sent;
    int status_seen [4];

    // Idling controls, shared between the test tasks and the drivers
    bit tx_idle;
    bit rx_idle;
    int rx_hold;    // long receiver hold-off, counted down by the receiver process
    int rx_wait;    // remaining cycles of the current short receiver stall

    // 10 time-unit clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Generous cap: even with every command hitting the longest stalls on both
    // sides the run stays well below this.
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Gap length: mostly none, often a short one, now and then a long one.
    function automatic int pick_gap(bit enabled);
        int r;
        if (!enabled) begin
            return 0;
        end
        r = $urandom_range(99);
        if (r < 55) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(30, 8);
    endfunction

    // Random word, with the sign and magnitude extremes showing up often
    function automatic t_word pick_word();
        case ($urandom_range(19))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return '0;
            3: return '1;
            default: return t_word'($urandom);
        endcase
    endfunction

    // Apply one command to the shadow list and return what the block must report.
    // Rejected commands leave the shadow untouched; codes 5..7 are no-ops with ok.
    function automatic t_list_result apply_list_command(logic [2:0] code,
                                                        logic [6:0] pos,
                                                        t_word word);
        t_list_result res;
        int           p;
        int           i;
        res.status     = ST_OK;
        res.read_value = '0;
        p              = int'(pos);
        case (code)
            CMD_PUSH: begin
                if (shadow_len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_words[IDX_W'(shadow_len)] = word;
                    shadow_len++;
                end
            end
            CMD_POP: begin
                if (shadow_len == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    shadow_len--;
                end
            end
            CMD_INSERT: begin
                // position check wins over the full check
                if (p > shadow_len) begin
                    res.status = ST_BADPOS;
                end else if (shadow_len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    for (i = shadow_len; i > p; i--) begin
                        shadow_words[IDX_W'(i)] = shadow_words[IDX_W'(i - 1)];
                    end
                    shadow_words[IDX_W'(p)] = word;
                    shadow_len++;
                end
            end
            CMD_DELETE: begin
                // empty check wins over the position check
                if (shadow_len == 0) begin
                    res.status = ST_EMPTY;
                end else if (p >= shadow_len) begin
                    res.status = ST_BADPOS;
                end else begin
                    for (i = p; i + 1 < shadow_len; i++) begin
                        shadow_words[IDX_W'(i)] = shadow_words[IDX_W'(i + 1)];
                    end
                    shadow_len--;
                end
            end
            CMD_READ: begin
                if (shadow_len == 0) begin
                    res.status = ST_EMPTY;
                end else if (p >= shadow_len) begin
                    res.status = ST_BADPOS;
                end else begin
                    res.read_value = shadow_words[IDX_W'(p)];
                end
            end
            default: begin
            end
        endcase
        res.count = shadow_len[6:0];
        return res;
    endfunction

    // Drive one command at the falling edge (after an optional gap) and hold it
    // until the block takes it. The expectation is recorded at the accepting edge,
    // so the shadow always reflects exactly the commands the block has taken.
    task automatic send_command(logic [2:0] code, logic [6:0] pos, t_word word);
        int gap;
        gap = pick_gap(tx_idle);
        @(negedge i_clk);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_bus.valid    <= 1'b1;
        in_bus.command  <= code;
        in_bus.position <= pos;
        in_bus.value    <= word;
        do @(posedge i_clk); while (!in_bus.ready);
        pending_results.push_back(apply_list_command(code, pos, word));
        commands_sent++;
    endtask

    // Drop valid and wait for every outstanding result to come back
    task automatic wait_drained();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Mostly well-formed traffic steered toward a fill level, plus some noise:
    // any code (including the unused ones) at any position.
    task automatic send_random_command(int target);
        int         r;
        bit         grow;
        logic [2:0] code;
        int         pos;
        r   = $urandom_range(99);
        pos = 0;
        if (r < 8) begin
            code = 3'($urandom_range(7));
            pos  = $urandom_range(127);
        end else if (r < 30) begin
            code = CMD_READ;
            if (shadow_len > 0) pos = $urandom_range(shadow_len - 1);
        end else begin
            grow = (shadow_len < target) ? ($urandom_range(9) < 8) : ($urandom_range(9) < 2);
            if (grow) begin
                if ($urandom_range(1)) begin
                    code = CMD_PUSH;
                end else begin
                    code = CMD_INSERT;
                    pos  = $urandom_range(shadow_len);
                end
            end else begin
                if ($urandom_range(1)) begin
                    code = CMD_POP;
                end else begin
                    code = CMD_DELETE;
                    if (shadow_len > 0) pos = $urandom_range(shadow_len - 1);
                end
            end
        end
        send_command(code, 7'(pos), pick_word());
    endtask

    // Empty-list rejects, sign extremes, middle insert/delete, out-of-range
    // positions, and the unused command codes.
    task automatic test_directed();
        send_command(CMD_POP,    7'd0,   '0);
        send_command(CMD_DELETE, 7'd0,   '0);
        send_command(CMD_READ,   7'd0,   '0);
        send_command(CMD_INSERT, 7'd1,   32'sh1234_5678);   // past the end of an empty list
        send_command(CMD_INSERT, 7'd0,   32'sh7FFF_FFFF);
        send_command(CMD_PUSH,   7'd0,   32'sh8000_0000);
        send_command(CMD_PUSH,   7'd0,   '1);
        send_command(CMD_PUSH,   7'd0,   '0);
        send_command(CMD_INSERT, 7'd2,   32'sh5A5A_A5A5);
        for (int k = 0; k < 5; k++) begin
            send_command(CMD_READ, 7'(k), '0);
        end
        send_command(CMD_READ,   7'd5,   '0);
        send_command(CMD_READ,   7'd127, '0);
        send_command(CMD_DELETE, 7'd5,   '0);
        send_command(CMD_DELETE, 7'd2,   '0);
        send_command(CMD_DELETE, 7'd0,   '0);
        send_command(3'd5,       7'd127, '1);
        send_command(3'd6,       7'd64,  32'sh8000_0000);
        send_command(3'd7,       7'd0,   32'sh7FFF_FFFF);
        send_command(CMD_POP,    7'd0,   '0);
        send_command(CMD_READ,   7'd0,   '0);
        wait_drained();
    endtask

    // Fill to capacity, hit the full-list cases at both ends, then empty it out.
    task automatic test_capacity();
        while (shadow_len < CAPACITY) begin
            if ($urandom_range(1))
                send_command(CMD_PUSH, 7'd0, pick_word());
            else
                send_command(CMD_INSERT, 7'($urandom_range(shadow_len)), pick_word());
        end
        send_command(CMD_PUSH,   7'd0,   pick_word());
        send_command(CMD_INSERT, 7'd64,  pick_word());  // valid spot, but no room
        send_command(CMD_INSERT, 7'd0,   pick_word());
        send_command(CMD_INSERT, 7'd65,  pick_word());  // position reject beats full
        send_command(CMD_INSERT, 7'd127, pick_word());
        send_command(CMD_READ,   7'd63,  '0);
        send_command(CMD_READ,   7'd64,  '0);
        send_command(CMD_DELETE, 7'd64,  '0);
        send_command(CMD_DELETE, 7'd63,  '0);
        send_command(CMD_INSERT, 7'd63,  pick_word());
        send_command(CMD_DELETE, 7'd0,   '0);
        send_command(CMD_PUSH,   7'd0,   pick_word());
        while (shadow_len > 0) begin
            if ($urandom_range(1))
                send_command(CMD_POP, 7'd0, '0);
            else
                send_command(CMD_DELETE, 7'($urandom_range(shadow_len - 1)), '0);
        end
        send_command(CMD_POP, 7'd0, '0);
        wait_drained();
    endtask

    // Receiver holds off for a long stretch while the sender streams back to
    // back, so the output register fills and the input has to stall.
    task automatic test_backpressure();
        tx_idle = 1'b0;
        rx_hold = 120;
        repeat (24) send_random_command(CAPACITY / 2);
        wait_drained();
    endtask

    // Bulk random traffic in phases with different fill targets (empty and full
    // among them) and different idling on both sides.
    task automatic test_random();
        int target;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: target = CAPACITY;
                1: target = 0;
                default: target = $urandom_range(CAPACITY);
            endcase
            tx_idle = (phase != 0) && (phase != 3);
            rx_idle = (phase != 0) && (phase != 2);
            repeat (200) send_random_command(target);
            wait_drained();
        end
    endtask

    // Receiver: ready changes only at the falling edge
    initial begin : drive_ready
        int gap;
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                out_bus.ready <= 1'b0;
                rx_hold--;
            end else if (rx_wait > 0) begin
                out_bus.ready <= 1'b0;
                rx_wait--;
            end else begin
                gap = pick_gap(rx_idle);
                if (gap > 0) begin
                    out_bus.ready <= 1'b0;
                    rx_wait = gap - 1;
                end else begin
                    out_bus.ready <= 1'b1;
                end
            end
        end
    end

    // Checker: every result transfer is compared against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_list_result exp;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing pending: status %0d count %0d read %0d",
                         $time, out_bus.status, out_bus.count, $signed(out_bus.read_value));
                mismatch_count++;
            end else begin
                exp = pending_results.pop_front();
                results_checked++;
                status_seen[exp.status]++;
                if (out_bus.status !== exp.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, exp.status, out_bus.status);
                    mismatch_count++;
                end
                if (out_bus.count !== exp.count) begin
                    $display("%0t: count mismatch, expected %0d, got %0d",
                             $time, exp.count, out_bus.count);
                    mismatch_count++;
                end
                if (out_bus.read_value !== exp.read_value) begin
                    $display("%0t: read_value mismatch, expected %0d, got %0d",
                             $time, exp.read_value, $signed(out_bus.read_value));
                    mismatch_count++;
                end
            end
        end
    end

    // Main sequence
    initial begin
        i_rst_n         = 1'b0;
        in_bus.valid    = 1'b0;
        in_bus.command  = '0;
        in_bus.position = '0;
        in_bus.value    = '0;
        shadow_len      = 0;
        mismatch_count  = 0;
        results_checked = 0;
        commands_sent   = 0;
        status_seen     = '{default: 0};
        tx_idle         = 1'b1;
        rx_idle         = 1'b1;
        rx_hold         = 0;
        rx_wait         = 0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_capacity();
        test_backpressure();
        test_random();

        // Spare cycles after draining catch any stray result
        wait_drained();
        repeat (4) @(posedge i_clk);

        $display("Covered %0d commands (directed, fill to capacity, long output stall, random).",
                 commands_sent);
        $display("Checked %0d results: ok %0d, bad position %0d, full %0d, empty %0d.",
                 results_checked, status_seen[ST_OK], status_seen[ST_BADPOS],
                 status_seen[ST_FULL], status_seen[ST_EMPTY]);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* positional_insert_delete_list.f */
hw/rtl/pidl_pkg.sv
hw/rtl/pidl_in_if.sv
hw/rtl/pidl_out_if.sv
hw/rtl/pidl_cell.sv
hw/rtl/pidl_ctrl.sv
hw/rtl/positional_insert_delete_list.sv
tb/sv/positional_insert_delete_list_test.sv
